>>> rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/ycpr_pkg.sv
`default_nettype none

package ycpr_pkg;

  // Fixed-point widths: 16.16 terms fit in 26 signed bits, channel sums in 28.
  localparam int unsigned TermW = 26;
  localparam int unsigned SumW  = 28;
  localparam int unsigned FracW = 16;

  // Coefficients scaled by 1000
  localparam int CoefY  = 1164;
  localparam int CoefRv = 1596;
  localparam int CoefGu = -392;
  localparam int CoefGv = -813;
  localparam int CoefBu = 2017;

  localparam int unsigned CfgAddrW = 3;

  typedef enum logic [3:0] {
    FMT_RGB555 = 4'd0,
    FMT_BGR555 = 4'd1,
    FMT_RGB565 = 4'd2,
    FMT_BGR565 = 4'd3,
    FMT_RGB24  = 4'd4,
    FMT_BGR24  = 4'd5,
    FMT_RGB32  = 4'd6,
    FMT_BGR32  = 4'd7,
    FMT_RGBA32 = 4'd8
  } fmt_e;

  typedef logic signed [TermW-1:0] term_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef term_t term_lut_t [256];

  typedef struct packed {
    term_t luma_first;
    term_t luma_second;
    term_t red_v;
    term_t green_u;
    term_t green_v;
    term_t blue_u;
  } terms_t;

  typedef struct packed {
    sum_t r;
    sum_t g;
    sum_t b;
  } rgb_sum_t;

  typedef struct packed {
    rgb_sum_t first;
    rgb_sum_t second;
  } sums_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t first;
    rgb_t second;
  } rgb_pair_t;

  // Luma term: scaled integer part first, then moved up to 16.16.
  function automatic term_lut_t build_luma_lut();
    term_lut_t lut;
    int k;
    for (int i = 0; i < 256; i++) begin
      k = i - 16;
      lut[i] = term_t'(((k * CoefY) / 1000) * 65536);
    end
    return lut;
  endfunction

  // Chroma term: coef*(c-128)*65536/1000, truncated toward zero.
  function automatic term_lut_t build_chroma_lut(input int coef);
    term_lut_t lut;
    longint d;
    for (int i = 0; i < 256; i++) begin
      d = longint'(i) - 128;
      lut[i] = term_t'((longint'(coef) * d * 8192) / 125);
    end
    return lut;
  endfunction

  localparam term_lut_t LumaLut   = build_luma_lut();
  localparam term_lut_t RedVLut   = build_chroma_lut(CoefRv);
  localparam term_lut_t GreenULut = build_chroma_lut(CoefGu);
  localparam term_lut_t GreenVLut = build_chroma_lut(CoefGv);
  localparam term_lut_t BlueULut  = build_chroma_lut(CoefBu);

endpackage

`default_nettype wire

>>> rtl/ycpr_lookup.sv
`default_nettype none

// Stage 1: table lookup of every luma and chroma term.
module ycpr_lookup (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire logic [7:0]      luma_first_i,
  input  wire logic [7:0]      luma_second_i,
  input  wire logic [7:0]      chroma_blue_i,
  input  wire logic [7:0]      chroma_red_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output ycpr_pkg::terms_t     terms_o
);
  import ycpr_pkg::*;

  logic   valid_q;
  terms_t terms_d, terms_q;

  // Advance when the stage is empty or downstream takes its beat
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    terms_d.luma_first  = LumaLut[luma_first_i];
    terms_d.luma_second = LumaLut[luma_second_i];
    terms_d.red_v       = RedVLut[chroma_red_i];
    terms_d.green_u     = GreenULut[chroma_blue_i];
    terms_d.green_v     = GreenVLut[chroma_red_i];
    terms_d.blue_u      = BlueULut[chroma_blue_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      terms_q <= terms_d;
    end
  end

  assign valid_o = valid_q;
  assign terms_o = terms_q;

endmodule

`default_nettype wire

>>> rtl/ycpr_sum_clamp.sv
`default_nettype none

// Stages 2 and 3: add the channel terms, then floor-shift and clamp to 0..255.
module ycpr_sum_clamp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire ycpr_pkg::terms_t  terms_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output ycpr_pkg::rgb_pair_t    rgb_o
);
  import ycpr_pkg::*;

  logic      sum_valid_q, sum_ready;
  sums_t     sums_d, sums_q;
  logic      rgb_valid_q;
  rgb_pair_t rgb_d, rgb_q;

  function automatic logic [7:0] clamp8(input sum_t s);
    logic signed [SumW-FracW-1:0] q;
    logic [7:0] res;
    q = s[SumW-1:FracW];
    if (q[SumW-FracW-1]) begin
      res = 8'd0;
    end else if (|q[SumW-FracW-2:8]) begin
      res = 8'hff;
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

  function automatic sum_t ext(input term_t t);
    return sum_t'(t);
  endfunction

  assign sum_ready = !rgb_valid_q || ready_i;
  assign ready_o   = !sum_valid_q || sum_ready;

  // Channel sums for both pixels
  always_comb begin
    sums_d.first.r  = ext(terms_i.luma_first) + ext(terms_i.red_v);
    sums_d.first.g  = ext(terms_i.luma_first) + ext(terms_i.green_u) + ext(terms_i.green_v);
    sums_d.first.b  = ext(terms_i.luma_first) + ext(terms_i.blue_u);
    sums_d.second.r = ext(terms_i.luma_second) + ext(terms_i.red_v);
    sums_d.second.g = ext(terms_i.luma_second) + ext(terms_i.green_u)
                      + ext(terms_i.green_v);
    sums_d.second.b = ext(terms_i.luma_second) + ext(terms_i.blue_u);
  end

  // Clamp every channel
  always_comb begin
    rgb_d.first.r  = clamp8(sums_q.first.r);
    rgb_d.first.g  = clamp8(sums_q.first.g);
    rgb_d.first.b  = clamp8(sums_q.first.b);
    rgb_d.second.r = clamp8(sums_q.second.r);
    rgb_d.second.g = clamp8(sums_q.second.g);
    rgb_d.second.b = clamp8(sums_q.second.b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      rgb_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        sum_valid_q <= valid_i;
      end
      if (sum_ready) begin
        rgb_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sums_q <= sums_d;
    end
    if (sum_ready && sum_valid_q) begin
      rgb_q <= rgb_d;
    end
  end

  // Stage 3 readiness toward the sum stage folds in the clamp register state
  assign valid_o = rgb_valid_q;
  assign rgb_o   = rgb_q;

endmodule

`default_nettype wire

>>> rtl/ycpr_pack.sv
`default_nettype none

// Stage 4: pack both pixels in the selected format; this is the output register.
module ycpr_pack (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [3:0]         format_i,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire ycpr_pkg::rgb_pair_t rgb_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [31:0]             pixel_first_o,
  output logic [31:0]             pixel_second_o
);
  import ycpr_pkg::*;

  logic        valid_q;
  logic [31:0] first_d, first_q, second_d, second_q;

  function automatic logic [31:0] pack(input logic [3:0] fmt, input rgb_t p);
    logic [31:0] res;
    unique case (fmt_e'(fmt))
      FMT_RGB555: res = {17'd0, p.r[7:3], p.g[7:3], p.b[7:3]};
      FMT_BGR555: res = {17'd0, p.b[7:3], p.g[7:3], p.r[7:3]};
      FMT_RGB565: res = {16'd0, p.r[7:3], p.g[7:2], p.b[7:3]};
      FMT_BGR565: res = {16'd0, p.b[7:3], p.g[7:2], p.r[7:3]};
      FMT_RGB24:  res = {8'd0, p.b, p.g, p.r};
      FMT_BGR24:  res = {8'd0, p.r, p.g, p.b};
      FMT_RGB32:  res = {8'd0, p.b, p.g, p.r};
      FMT_BGR32:  res = {8'd0, p.r, p.g, p.b};
      FMT_RGBA32: res = {8'hff, p.b, p.g, p.r};
      default:    res = 32'd0;
    endcase
    return res;
  endfunction

  assign ready_o  = !valid_q || ready_i;
  assign first_d  = pack(format_i, rgb_i.first);
  assign second_d = pack(format_i, rgb_i.second);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the beat while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign valid_o        = valid_q;
  assign pixel_first_o  = first_q;
  assign pixel_second_o = second_q;

endmodule

`default_nettype wire

>>> rtl/ycbcr_pair_to_packed_rgb.sv
// YCbCr pixel pair to packed RGB converter (BT.601, 16.16 fixed point).
// Input stream: one beat carries two luma samples and the Cb/Cr pair they share.
// Output stream: one beat carries both pixels packed in the selected format,
// first memory byte in the low bits; unused high bits read as zero.
// Configuration: APB register 0 (address 0) holds output_format, 4 bits;
// codes 9..15 give zero pixels. Write it only while the pipeline is empty.
// Pipeline: term lookup, channel sum, clamp and packing, each in its own
// registered stage.
// Throughput: one pair per clock unless the output stalls; every stage registers
// its beat and takes a new one when empty or when its successor takes its beat.
// Reset: all valid bits clear, the pipeline is empty and output_format = rgb555.
// Stall: the output beat holds; the stages behind it keep filling until all four
// hold a beat, then s_axis_tready drops. No beat is lost or repeated.
`default_nettype none

module ycbcr_pair_to_packed_rgb (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // luma_first [7:0], luma_second [15:8], chroma_blue [23:16], chroma_red [31:24]
  input  wire logic [31:0]                        s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // pixel_first [31:0], pixel_second [63:32]
  output logic [63:0]                             m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ycpr_pkg::CfgAddrW-1:0]      paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import ycpr_pkg::*;

  logic [3:0] format_q;
  logic       cfg_sel;

  logic       lk_valid, lk_ready;
  terms_t     lk_terms;
  logic       sc_valid, sc_ready;
  rgb_pair_t  sc_rgb;

  // Register decode: word address 0 only
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[CfgAddrW-1:2] == '0);
  assign prdata  = cfg_sel ? {28'd0, format_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FMT_RGB555;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      format_q <= pwdata[3:0];
    end
  end

  ycpr_lookup u_lookup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .luma_first_i  (s_axis_tdata[7:0]),
    .luma_second_i (s_axis_tdata[15:8]),
    .chroma_blue_i (s_axis_tdata[23:16]),
    .chroma_red_i  (s_axis_tdata[31:24]),
    .valid_o       (lk_valid),
    .ready_i       (lk_ready),
    .terms_o       (lk_terms)
  );

  ycpr_sum_clamp u_sum_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lk_valid),
    .ready_o (lk_ready),
    .terms_i (lk_terms),
    .valid_o (sc_valid),
    .ready_i (sc_ready),
    .rgb_o   (sc_rgb)
  );

  ycpr_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .format_i       (format_q),
    .valid_i        (sc_valid),
    .ready_o        (sc_ready),
    .rgb_i          (sc_rgb),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .pixel_first_o  (m_axis_tdata[31:0]),
    .pixel_second_o (m_axis_tdata[63:32])
  );

endmodule

`default_nettype wire

>>> rtl/ycpr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ycpr_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic [31:0]                   s_axis_tdata,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [63:0]                   m_axis_tdata,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [ycpr_pkg::CfgAddrW-1:0] paddr,
  input wire logic [31:0]                   pwdata,
  input wire logic [31:0]                   prdata,
  input wire logic                          pready
);

  // A stalled output beat holds its data
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

  // An empty output stage means the whole pipeline can take a beat
  `ASSERT_CLK(a_ready_when_drained, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "input stalled with an empty pipeline")

  // Only rgba32 sets the top byte, and then to all ones
  `ASSERT_CLK(a_top_byte, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[31:24] != 8'h00) |-> (m_axis_tdata[31:24] == 8'hff) && (m_axis_tdata[63:56] == 8'hff), "bad alpha byte")

  // Format register reads back as 4 bits
  `ASSERT_ALWAYS(a_prdata_width, clk_i, prdata[31:4] == 28'd0, "register read beyond its width")

endmodule

bind ycbcr_pair_to_packed_rgb ycpr_checker u_checker (.*);

`default_nettype wire
